// File: hw/rtl/iol_pkg.sv
// shared constants, codes and types for the indexed ordered list unit
package iol_pkg;

  // field widths
  localparam int POS_W        = 7;
  localparam int VAL_W        = 32;
  localparam int CMD_W        = 3;
  localparam int STAT_W       = 2;
  localparam int LEN_W        = 7;
  localparam int DEF_CAPACITY = 64;

  // command codes
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_AT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_FINISH
  } state_t;

  // decoded command, passed from decode to sequencer
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              do_read;
    logic              do_insert;
    logic              do_delete;
    logic              need_shift;
  } dec_t;

endpackage

// File: hw/rtl/iol_ram.sv
// generic single write port ram with registered read
module iol_ram
  #(parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH))
  (input  logic             clk,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/iol_decode.sv
// command decode: range and full checks, new length, effective position
module iol_decode
  import iol_pkg::*;
  #(parameter int CAPACITY = DEF_CAPACITY,
    localparam int CW = ($clog2(CAPACITY + 1) > POS_W) ? $clog2(CAPACITY + 1) : POS_W)
  (input  logic [CMD_W-1:0] command,
   input  logic [POS_W-1:0] position,
   input  logic [CW-1:0]    count,
   output dec_t             dec,
   output logic [CW-1:0]    eff_pos,
   output logic [CW-1:0]    new_count);

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] pos_p1;

  assign pos_ext = CW'(position);
  assign pos_p1  = pos_ext + 1'b1;

  // per-command checks
  always_comb begin
    dec       = '0;
    dec.status = STAT_DONE;
    eff_pos   = pos_ext;
    new_count = count;
    unique case (command)
      CMD_READ: begin
        if (pos_ext < count) begin
          dec.do_read = 1'b1;
        end else begin
          dec.status = STAT_RANGE;
        end
      end
      CMD_HEAD, CMD_TAIL, CMD_AT: begin
        if (command == CMD_HEAD) begin
          eff_pos = '0;
        end else if (command == CMD_TAIL) begin
          eff_pos = count;
        end
        if (eff_pos > count) begin
          dec.status = STAT_RANGE;
        end else if (count >= CAP_C) begin
          dec.status = STAT_FULL;
        end else begin
          dec.do_insert  = 1'b1;
          dec.need_shift = count > eff_pos;
          new_count      = count + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (pos_ext < count) begin
          dec.do_delete  = 1'b1;
          dec.need_shift = pos_p1 < count;
          new_count      = count - 1'b1;
        end else begin
          dec.status = STAT_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/indexed_ordered_list_unit.sv
// top level: indexed ordered list with a sequenced entry shifter
//
// Input beats carry a command (read, insert head, insert tail, insert at
// position, delete), a position and a value. Each input beat yields exactly
// one output beat: read value (zero unless a read hit), status and the list
// length after the command. in_stall is high while a command is in progress.
// A read or rejected command goes straight to its result. An insert at p
// with n entries first moves the n-p entries from p upward by one, then
// writes the value at p; a delete at p moves the n-p-1 entries above p
// down by one. Entries move one at a time: the entry RAM has one read port
// with a registered output and one write port, and the sequencer reads each
// entry then writes it. The next input beat is taken once the sequencer is
// back in idle, which happens in the same cycle that out_valid rises.
// The result sits in an output register; a new command may start while it
// waits, but its own result is held back until the previous one is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending beat;
// the RAM contents are not cleared, since only written entries are ever read.
module indexed_ordered_list_unit
  import iol_pkg::*;
  #(parameter int CAPACITY = DEF_CAPACITY)
  (input  logic                    clk,
   input  logic                    rst_n,
   input  logic                    in_valid,
   output logic                    in_stall,
   input  logic [CMD_W-1:0]        in_command,
   input  logic [POS_W-1:0]        in_position,
   input  logic signed [VAL_W-1:0] in_item_value,
   output logic                    out_valid,
   input  logic                    out_stall,
   output logic signed [VAL_W-1:0] out_read_value,
   output logic [STAT_W-1:0]       out_status,
   output logic [LEN_W-1:0]        out_list_length);

  localparam int CW = ($clog2(CAPACITY + 1) > POS_W) ? $clog2(CAPACITY + 1) : POS_W;
  localparam int AW = $clog2(CAPACITY);

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              is_read_r, is_read_nxt;
  logic              is_del_r, is_del_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]  out_value_r, out_value_nxt;
  logic [STAT_W-1:0] out_status_r, out_status_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  dec_t              dec;
  logic [CW-1:0]     eff_pos;
  logic [CW-1:0]     dec_count;
  logic              accept;
  logic [CW-1:0]     idx_m1;
  logic [CW-1:0]     idx_p1;

  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;
  logic              ram_wr_en;
  logic [AW-1:0]     ram_wr_addr;
  logic [VAL_W-1:0]  ram_wr_data;

  // command checks against the current length
  iol_decode #(.CAPACITY(CAPACITY)) u_decode (
    .command   (in_command),
    .position  (in_position),
    .count     (count_r),
    .dec       (dec),
    .eff_pos   (eff_pos),
    .new_count (dec_count)
  );

  // entry storage
  iol_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_ram (
    .clk     (clk),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data)
  );

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign idx_m1   = idx_r - 1'b1;
  assign idx_p1   = idx_r + 1'b1;

  // sequencer next state and ram control
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    pos_nxt        = pos_r;
    value_nxt      = value_r;
    status_nxt     = status_r;
    is_read_nxt    = is_read_r;
    is_del_nxt     = is_del_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = eff_pos[AW-1:0];
    ram_wr_en      = 1'b0;
    ram_wr_addr    = idx_r[AW-1:0];
    ram_wr_data    = ram_rd_data;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          count_nxt   = dec_count;
          pos_nxt     = eff_pos;
          value_nxt   = in_item_value;
          status_nxt  = dec.status;
          is_read_nxt = dec.do_read;
          is_del_nxt  = dec.do_delete;
          idx_nxt     = dec.do_delete ? eff_pos : count_r;
          ram_rd_en   = dec.do_read;
          if (dec.need_shift) begin
            state_nxt = ST_SHIFT_RD;
          end else if (dec.do_insert) begin
            state_nxt = ST_PUT;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_SHIFT_RD: begin
        // fetch the neighbor that moves into idx
        ram_rd_en   = 1'b1;
        ram_rd_addr = is_del_r ? idx_p1[AW-1:0] : idx_m1[AW-1:0];
        state_nxt   = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        ram_wr_en = 1'b1;
        if (is_del_r) begin
          idx_nxt   = idx_p1;
          state_nxt = (idx_p1 < count_r) ? ST_SHIFT_RD : ST_FINISH;
        end else begin
          idx_nxt   = idx_m1;
          state_nxt = (idx_m1 > pos_r) ? ST_SHIFT_RD : ST_PUT;
        end
      end
      ST_PUT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = pos_r[AW-1:0];
        ram_wr_data = value_r;
        state_nxt   = ST_FINISH;
      end
      ST_FINISH: begin
        // hand the result to the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = is_read_r ? ram_rd_data : '0;
          out_status_nxt = status_r;
          out_len_nxt    = count_r[LEN_W-1:0];
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    pos_r        <= pos_nxt;
    value_r      <= value_nxt;
    status_r     <= status_nxt;
    is_read_r    <= is_read_nxt;
    is_del_r     <= is_del_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_value_r;
  assign out_status      = out_status_r;
  assign out_list_length = out_len_r;

endmodule
